// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the row max downscaler RTL
// Concurrent checks on clk, disabled during rst; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/wrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrd_pkg
// Constants and types for the waterfall row max downscaler.
// ----------------------------------------------------------------------------
package wrd_pkg;

  // Display geometry
  localparam int         DISPLAY_COLUMNS = 240;
  localparam logic [7:0] LAST_COLUMN     = 8'(DISPLAY_COLUMNS - 1);

  // Configuration register indexes and reset values
  localparam int         CFG_INDEX_W     = 4;
  localparam logic [3:0] CFG_BIN_COUNT   = 4'd0;
  localparam logic [3:0] CFG_PASSES      = 4'd1;
  localparam int         BIN_CFG_W       = 11;
  localparam int         PASS_CFG_W      = 3;
  localparam logic [10:0] BIN_COUNT_RESET = 11'd448;
  localparam logic [2:0]  PASSES_RESET    = 3'd2;

  // Clamp limits
  localparam int MIN_BINS   = 4;
  localparam int MAX_PASSES = 4;

  // Reciprocal of DISPLAY_COLUMNS, scaled by 2^RECIP_SHIFT and rounded down
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = 273;

  // Row restart sequencer
  typedef enum logic [1:0] {
    RS_IDLE,
    RS_MUL,
    RS_DIV,
    RS_LOAD
  } restart_state_t;

  // One emitted column
  typedef struct packed {
    logic [7:0] index;
    logic [7:0] value;
    logic       run_last;
    logic       row_end;
  } col_result_t;

endpackage

// ===== rtl/waterfall_row_max_downscale.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// waterfall_row_max_downscale
// Collapses oversampled spectrum rows to a fixed number of display columns.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid, in_stall, magnitude): one bin byte per
//    transaction, pass by pass, bin by bin within a pass.
//  - Output channel (out_valid, out_stall, column_index, column_value,
//    run_last, row_end): one display column per transaction. run_last
//    marks the last column closed by one input byte; row_end marks the
//    final column of the row.
//  - Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 is
//    the bin count, index 1 the pass count. Writing either restarts the row.
//  - Throughput: one byte per cycle while in_stall is low. In the last
//    pass a byte that closes k columns holds the column unit until they
//    are all emitted, one column per cycle while the output is free, and
//    the input stalls meanwhile. The bin store is read on acceptance and
//    written back as the byte leaves the read stage.
//  - Reset and each restarting config write run the multiply, divide and
//    load states, working out B/240 for the column boundaries; in_stall
//    is high meanwhile. A column passes from the read stage through the
//    held bin register of the column unit into the output register.
//  - A stalled output holds its register; the pipeline keeps taking bytes until the column unit has a column waiting.
// ----------------------------------------------------------------------------
module waterfall_row_max_downscale
  import wrd_pkg::*;
#(
  parameter int MAX_BINS = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  // input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             magnitude,
  // output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             column_index,
  output logic [7:0]             column_value,
  output logic                   run_last,
  output logic                   row_end,
  // configuration
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BIN_CFG_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_BINS);
  localparam int NW = $clog2(MAX_BINS + 1);
  localparam int SW = NW + 1;
  localparam int CW = (NW > BIN_CFG_W) ? NW : BIN_CFG_W;
  localparam int PW = SW + RECIP_SHIFT;
  localparam int RW = SW + 8;

  // Configuration registers
  logic [BIN_CFG_W-1:0]  bin_count;
  logic [PASS_CFG_W-1:0] oversample_passes;
  logic                  cfg_wr;
  logic                  cfg_hit;
  logic [CW-1:0]         bc_ext;
  logic [SW-1:0]         nb_eff;
  logic [2:0]            np_eff;

  // Restart sequencer
  restart_state_t rs, rs_next;
  logic           seq_busy;
  logic           mul_en;
  logic           div_en;
  logic           restart;

  // B/240 by reciprocal
  logic [PW-1:0] prod;
  logic [SW-1:0] q_est;
  logic [RW-1:0] qe240;
  logic [RW-1:0] r_est;
  logic          fix;
  logic [SW-1:0] nb_q, nb_q_next;
  logic [7:0]    nb_r, nb_r_next;

  // Row position
  logic [AW-1:0] bin_ctr;
  logic [1:0]    pass_ctr;
  logic          bin_last;
  logic          pass_last;
  logic          in_acc;

  // Read-modify-write stage
  logic          s1_valid;
  logic [7:0]    s1_m;
  logic [AW-1:0] s1_b;
  logic          s1_first;
  logic          s1_final;
  logic          s1_adv;
  logic [7:0]    rd_data;
  logic [7:0]    v;
  logic [7:0]    peak_mem [MAX_BINS];

  // Column unit
  logic        item_take;
  logic        emit;
  logic        out_free;
  col_result_t col_res;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_wr && ((cfg_index == CFG_BIN_COUNT) || (cfg_index == CFG_PASSES));

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count         <= BIN_COUNT_RESET;
      oversample_passes <= PASSES_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_BIN_COUNT: bin_count         <= cfg_data;
        CFG_PASSES:    oversample_passes <= cfg_data[PASS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped bin and pass counts
  always_comb begin
    bc_ext = CW'(bin_count);
    if (bc_ext < CW'(MIN_BINS)) begin
      nb_eff = SW'(MIN_BINS);
    end else if (bc_ext > CW'(MAX_BINS)) begin
      nb_eff = SW'(MAX_BINS);
    end else begin
      nb_eff = SW'(bc_ext);
    end
    if (oversample_passes == 3'd0) begin
      np_eff = 3'd1;
    end else if (oversample_passes > 3'(MAX_PASSES)) begin
      np_eff = 3'(MAX_PASSES);
    end else begin
      np_eff = oversample_passes;
    end
  end

  // Sequencer: state register
  always_ff @(posedge clk) begin
    if (rst) begin
      rs <= RS_MUL;
    end else begin
      rs <= rs_next;
    end
  end

  // Sequencer: next state
  always_comb begin
    rs_next = rs;
    if (cfg_hit) begin
      rs_next = RS_MUL;
    end else begin
      case (rs)
        RS_IDLE: rs_next = RS_IDLE;
        RS_MUL:  rs_next = RS_DIV;
        RS_DIV:  rs_next = RS_LOAD;
        RS_LOAD: rs_next = RS_IDLE;
        default: rs_next = RS_IDLE;
      endcase
    end
  end

  // Sequencer: outputs
  always_comb begin
    seq_busy = (rs != RS_IDLE);
    mul_en   = (rs == RS_MUL);
    div_en   = (rs == RS_DIV);
    restart  = (rs == RS_LOAD);
  end

  // Quotient estimate is low by at most one; one correction step
  always_comb begin
    q_est     = SW'(prod >> RECIP_SHIFT);
    qe240     = (RW'(q_est) << 8) - (RW'(q_est) << 4);
    r_est     = RW'(nb_eff) - qe240;
    fix       = (r_est >= RW'(DISPLAY_COLUMNS));
    nb_q_next = q_est + SW'(fix);
    nb_r_next = fix ? 8'(r_est - RW'(DISPLAY_COLUMNS)) : 8'(r_est);
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PW'(nb_eff) * PW'(RECIP);
    end
    if (div_en) begin
      nb_q <= nb_q_next;
      nb_r <= nb_r_next;
    end
  end

  // Input handshake
  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && (!s1_final || item_take);
  assign in_stall = seq_busy || (s1_valid && !s1_adv);
  assign in_acc   = in_valid && !in_stall;

  // Pass and bin counters
  assign bin_last  = ((SW'(bin_ctr) + SW'(1)) >= nb_eff);
  assign pass_last = ((3'(pass_ctr) + 3'd1) >= np_eff);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      bin_ctr  <= '0;
      pass_ctr <= '0;
    end else if (in_acc) begin
      if (bin_last) begin
        bin_ctr  <= '0;
        pass_ctr <= pass_last ? 2'd0 : pass_ctr + 2'd1;
      end else begin
        bin_ctr <= bin_ctr + AW'(1);
      end
    end
  end

  // Read-modify-write stage
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_m     <= magnitude;
      s1_b     <= bin_ctr;
      s1_first <= (pass_ctr == 2'd0);
      s1_final <= pass_last;
    end
  end

  // First pass overwrites, later passes keep the larger value
  assign v = (s1_first || (s1_m > rd_data)) ? s1_m : rd_data;

  // Bin peak store. Consecutive accesses are to consecutive bins and the
  // row has at least four bins, so the read and write never meet.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      peak_mem[s1_b] <= v;
    end
    if (in_acc) begin
      rd_data <= peak_mem[bin_ctr];
    end
  end

  wrd_column_pool #(
    .SW (SW)
  ) u_pool (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .step_q     (nb_q),
    .step_r     (nb_r),
    .item_valid (s1_valid && s1_final),
    .item_v     (v),
    .item_b     (SW'(s1_b)),
    .item_take  (item_take),
    .out_free   (out_free),
    .emit       (emit),
    .result     (col_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      column_index <= col_res.index;
      column_value <= col_res.value;
      run_last     <= col_res.run_last;
      row_end      <= col_res.row_end;
    end
  end

  `ASSERT_IMPLIES(a_rmw_no_clash, in_acc && s1_adv, bin_ctr != s1_b,
    "bin store read and write at the same address")
  `ASSERT_IMPLIES(a_row_end_last, out_valid && row_end, run_last,
    "row end without run last")
  `ASSERT_IMPLIES(a_row_end_col, out_valid && row_end, column_index == LAST_COLUMN,
    "row end on a column other than the last")

endmodule

// ===== rtl/wrd_column_pool.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// wrd_column_pool
// Column max-pooling unit: takes one collapsed bin peak at a time and emits
// the display columns closing on that bin, one per cycle while out_free.
// ----------------------------------------------------------------------------
module wrd_column_pool
  import wrd_pkg::*;
#(
  parameter int SW = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic [SW-1:0]     step_q,
  input  logic [7:0]        step_r,
  input  logic              item_valid,
  input  logic [7:0]        item_v,
  input  logic [SW-1:0]     item_b,
  output logic              item_take,
  input  logic              out_free,
  output logic              emit,
  output col_result_t       result
);

  // Held bin
  logic          e_valid;
  logic          e_fresh;
  logic [7:0]    e_v;
  logic [SW-1:0] e_b;

  // Column state: s0..s2 are the start bins of columns x, x+1 and x+2,
  // r2 the remainder of (x+2)*B over the column count
  logic [7:0]    col_x;
  logic [7:0]    col_peak;
  logic [SW-1:0] s0, s1, s2;
  logic [7:0]    r2;

  logic [SW-1:0] b1;
  logic [SW-1:0] end_cur;
  logic [SW-1:0] end_nxt;
  logic [7:0]    peak_eff;
  logic          hit;
  logic          last_col;
  logic          run_last_c;
  logic          done;
  logic [8:0]    r_sum;
  logic          r_wrap;
  logic [7:0]    r2_step;
  logic [SW-1:0] s2_step;
  logic [8:0]    r_dbl;
  logic          i_wrap;
  logic [7:0]    i_r2;
  logic [SW-1:0] i_s2;

  // Column boundaries and emit decision
  always_comb begin
    b1         = e_b + SW'(1);
    end_cur    = (s1 > s0) ? s1 : s0 + SW'(1);
    end_nxt    = (s2 > s1) ? s2 : s1 + SW'(1);
    peak_eff   = (e_fresh && (e_v > col_peak)) ? e_v : col_peak;
    hit        = e_valid && (b1 >= end_cur);
    last_col   = (col_x == LAST_COLUMN);
    run_last_c = last_col || (b1 < end_nxt);
    emit       = hit && out_free;
    done       = e_valid && (!hit || (out_free && run_last_c));
    item_take  = !e_valid || done;
  end

  // Next column start: add B/240 as quotient and remainder
  always_comb begin
    r_sum   = {1'b0, r2} + {1'b0, step_r};
    r_wrap  = (r_sum >= 9'(DISPLAY_COLUMNS));
    r2_step = r_wrap ? 8'(r_sum - 9'(DISPLAY_COLUMNS)) : r_sum[7:0];
    s2_step = s2 + step_q + SW'(r_wrap);
  end

  // Start of column two for a fresh row
  always_comb begin
    r_dbl  = {step_r, 1'b0};
    i_wrap = (r_dbl >= 9'(DISPLAY_COLUMNS));
    i_r2   = i_wrap ? 8'(r_dbl - 9'(DISPLAY_COLUMNS)) : r_dbl[7:0];
    i_s2   = (step_q << 1) + SW'(i_wrap);
  end

  always_comb begin
    result.index    = col_x;
    result.value    = peak_eff;
    result.run_last = run_last_c;
    result.row_end  = last_col;
  end

  // Held bin control
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      e_valid <= 1'b0;
    end else if (item_take) begin
      e_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      e_fresh <= 1'b1;
      e_v     <= item_v;
      e_b     <= item_b;
    end else if (emit) begin
      e_fresh <= 1'b0;
    end
  end

  // Column counter and running peak
  always_ff @(posedge clk) begin
    if (rst || restart || (emit && last_col)) begin
      col_x    <= '0;
      col_peak <= '0;
    end else if (emit) begin
      col_x    <= col_x + 8'd1;
      col_peak <= (s1 <= e_b) ? e_v : 8'd0;
    end else if (e_valid && !hit) begin
      col_peak <= peak_eff;
    end
  end

  // Column start bins
  always_ff @(posedge clk) begin
    if (restart || (emit && last_col)) begin
      s0 <= '0;
      s1 <= step_q;
      s2 <= i_s2;
      r2 <= i_r2;
    end else if (emit) begin
      s0 <= s1;
      s1 <= s2;
      s2 <= s2_step;
      r2 <= r2_step;
    end
  end

  `ASSERT_NEXT(a_item_stays, emit && !result.run_last && !restart, e_valid,
    "bin released before its last column")
  `ASSERT_IMPLIES(a_starts_ordered, e_valid, s1 >= s0, "column starts out of order")
  `ASSERT_IMPLIES(a_rem_range, e_valid, r2 < 8'(DISPLAY_COLUMNS),
    "column start remainder out of range")

endmodule
